/* hdl/i2d_pkg.sv */
// ----------------------------------------------------------------------------
// i2d_pkg
// Shared types and constants for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package i2d_pkg;

  localparam int DIGIT_W       = 4;
  localparam int BITS_PER_STEP = 4;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic {
    OP_SIGNED   = 1'b0,
    OP_UNSIGNED = 1'b1
  } opcode_t;

  typedef struct packed {
    logic load;
    logic convert;
    logic emit_sign;
    logic shift_digit;
    logic final_digit;
  } cmd_t;

  typedef struct packed {
    logic negative;
  } status_t;

  // decimal digits of 2^w - 1: floor(w * log10(2)) + 1
  function automatic int dec_digit_count(input int w);
    dec_digit_count = ((w * 1233) >> 12) + 1;
  endfunction

  // conversion steps of BITS_PER_STEP bits each
  function automatic int conv_steps(input int w);
    conv_steps = (w + BITS_PER_STEP - 1) / BITS_PER_STEP;
  endfunction

endpackage

/* hdl/i2d_ctrl.sv */
// ----------------------------------------------------------------------------
// i2d_ctrl
// Sequencer: load, binary to BCD conversion steps, sign, digit emission.
// ----------------------------------------------------------------------------
module i2d_ctrl
  import i2d_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output cmd_t    cmd,
  input  status_t status
);

  localparam int STEPS      = conv_steps(VALUE_WIDTH);
  localparam int NDIG       = dec_digit_count(VALUE_WIDTH);
  localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int DIG_CNT_W  = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(STEPS - 1);
  localparam logic [DIG_CNT_W-1:0]  DIG_LAST  = DIG_CNT_W'(NDIG - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  state_t                  state_r;
  logic [STEP_CNT_W-1:0]   step_cnt_r;
  logic [DIG_CNT_W-1:0]    dig_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      step_cnt_r <= '0;
      dig_cnt_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          step_cnt_r <= '0;
          dig_cnt_r  <= '0;
          if (start) begin
            state_r <= ST_CONV;
          end
        end
        ST_CONV: begin
          step_cnt_r <= step_cnt_r + 1'b1;
          if (step_cnt_r == STEP_LAST) begin
            state_r <= status.negative ? ST_SIGN : ST_DIGITS;
          end
        end
        ST_SIGN: begin
          state_r <= ST_DIGITS;
        end
        ST_DIGITS: begin
          dig_cnt_r <= dig_cnt_r + 1'b1;
          if (dig_cnt_r == DIG_LAST) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.load        = (state_r == ST_IDLE) && start;
    cmd.convert     = (state_r == ST_CONV);
    cmd.emit_sign   = (state_r == ST_SIGN);
    cmd.shift_digit = (state_r == ST_DIGITS);
    cmd.final_digit = (state_r == ST_DIGITS) && (dig_cnt_r == DIG_LAST);
  end

endmodule

/* hdl/i2d_dpath.sv */
// ----------------------------------------------------------------------------
// i2d_dpath
// Magnitude, shift-and-add-3 BCD conversion and registered character output.
// ----------------------------------------------------------------------------
module i2d_dpath
  import i2d_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   in_opcode,
  output logic                   out_valid,
  output logic [7:0]             out_character,
  output logic                   out_last
);

  localparam int STEPS = conv_steps(VALUE_WIDTH);
  localparam int NDIG  = dec_digit_count(VALUE_WIDTH);
  localparam int MAG_W = STEPS * BITS_PER_STEP;
  localparam int BCD_W = NDIG * DIGIT_W;

  logic [MAG_W-1:0]       bin_r;
  logic [MAG_W-1:0]       bin_nxt;
  logic [BCD_W-1:0]       bcd_r;
  logic [BCD_W-1:0]       bcd_nxt;
  logic                   negative_r;
  logic                   started_r;
  logic                   out_valid_r;
  logic [7:0]             out_character_r;
  logic                   out_last_r;

  logic                   negative;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic [DIGIT_W-1:0]     top_digit;
  logic                   digit_emit;

  assign negative  = (opcode_t'(in_opcode) == OP_SIGNED) && in_value[VALUE_WIDTH-1];
  assign magnitude = negative ? (~in_value + 1'b1) : in_value;

  // BITS_PER_STEP shift-and-add-3 steps per convert cycle
  always_comb begin
    bcd_nxt = bcd_r;
    bin_nxt = bin_r;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_nxt[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
          bcd_nxt[d*DIGIT_W +: DIGIT_W] = bcd_nxt[d*DIGIT_W +: DIGIT_W] + 4'd3;
        end
      end
      {bcd_nxt, bin_nxt} = {bcd_nxt[BCD_W-2:0], bin_nxt, 1'b0};
    end
  end

  assign top_digit  = bcd_r[BCD_W-1 -: DIGIT_W];
  // drop leading zeros, but always keep the final digit
  assign digit_emit = started_r || (top_digit != '0) || cmd.final_digit;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r      <= MAG_W'(magnitude);
      bcd_r      <= '0;
      negative_r <= negative;
    end else if (cmd.convert) begin
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end else if (cmd.shift_digit) begin
      bcd_r <= {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
    out_character_r <= cmd.emit_sign ? CHAR_MINUS : (CHAR_ZERO + 8'(top_digit));
    out_last_r      <= cmd.final_digit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        started_r <= 1'b0;
      end else if (cmd.shift_digit && (top_digit != '0)) begin
        started_r <= 1'b1;
      end
      out_valid_r <= cmd.emit_sign || (cmd.shift_digit && digit_emit);
    end
  end

  assign status.negative = negative_r;
  assign out_valid       = out_valid_r;
  assign out_character   = out_character_r;
  assign out_last        = out_last_r;

endmodule

/* hdl/int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Converts one word to its decimal ASCII text, one character per strobe.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The word is read as
// signed two's complement (opcode 0) or unsigned (opcode 1). Characters come
// out most significant first, each on out_character for one cycle with
// out_valid high; a negative value is led by '-', zero gives a single '0',
// and out_last marks the final digit. The receiver cannot stall. Busy stays
// high through ceil(VALUE_WIDTH/4) binary-to-BCD steps (four bits per cycle),
// a sign slot if the value is negative, and one slot per decimal digit
// (leading zero slots produce no strobe); a new request is taken only once
// busy has dropped again.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii
  import i2d_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   in_opcode,
  output logic                   out_valid,
  output logic [7:0]             out_character,
  output logic                   out_last
);

  cmd_t    cmd;
  status_t status;

  i2d_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  i2d_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_value      (in_value),
    .in_opcode     (in_opcode),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last)
  );

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == CHAR_MINUS) ||
                  ((out_character >= CHAR_ZERO) && (out_character <= CHAR_NINE)))
    else $error("illegal character on output");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_character == CHAR_MINUS)) |-> !out_last)
    else $error("sign flagged as last character");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("character emitted right after last");

endmodule
